/* rtl/ipfmt_pkg.sv */
// Package for the IP address text formatter: sequencer states, character
// codes, the mapped-address prefix and the byte-to-decimal helper.
// No dependencies.
`default_nettype none

package ipfmt_pkg;

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_SCAN = 10'b00_0000_0010,
        ST_GRP  = 10'b00_0000_0100,
        ST_DC2  = 10'b00_0000_1000,
        ST_SKIP = 10'b00_0001_0000,
        ST_HEX  = 10'b00_0010_0000,
        ST_PFX  = 10'b00_0100_0000,
        ST_BYTE = 10'b00_1000_0000,
        ST_DEC  = 10'b01_0000_0000,
        ST_DOT  = 10'b10_0000_0000
    } state_t;

    // One character headed for the output stage
    typedef struct packed {
        logic       valid;
        logic [6:0] code;
        logic       last;
    } ch_t;

    // Decimal digits of one byte, leading zeros dropped, top digit in [11:8]
    typedef struct packed {
        logic [11:0] digits;
        logic [1:0]  count;
    } dec_t;

    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_HEX_A  = 7'h57;  // 'a' minus ten
    localparam logic [6:0] CH_COLON  = 7'h3a;
    localparam logic [6:0] CH_DOT    = 7'h2e;

    localparam int unsigned PFX_LEN = 7;
    localparam logic [6:0] MAPPED_PFX [PFX_LEN] = '{
        7'h3a, 7'h3a, 7'h66, 7'h66, 7'h66, 7'h66, 7'h3a
    };

    // Lowercase hex character of one nibble
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] base;
        base = (nib < 4'd10) ? CH_ZERO : CH_HEX_A;
        return base + {3'd0, nib};
    endfunction

    // Split a byte into decimal digits; tens through a reciprocal multiply
    function automatic dec_t dec8(input logic [7:0] v);
        logic [3:0]  h;
        logic [7:0]  r;
        logic [14:0] q;
        logic [3:0]  t;
        logic [7:0]  o;
        dec_t        d;
        if (v >= 8'd200) begin
            h = 4'd2;
            r = v - 8'd200;
        end else if (v >= 8'd100) begin
            h = 4'd1;
            r = v - 8'd100;
        end else begin
            h = 4'd0;
            r = v;
        end
        q = {8'd0, r[6:0]} * 15'd205;
        t = q[14:11];
        o = r - {t, 3'd0} - {3'd0, t, 1'b0};
        if (v >= 8'd100) begin
            d.digits = {h, t, o[3:0]};
            d.count  = 2'd3;
        end else if (v >= 8'd10) begin
            d.digits = {t, o[3:0], 4'd0};
            d.count  = 2'd2;
        end else begin
            d.digits = {o[3:0], 8'd0};
            d.count  = 2'd1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/ipfmt_out_stage.sv */
// Output register of the IP address text formatter: holds one character
// until the receiver takes it. Depends on ipfmt_pkg.
`default_nettype none

module ipfmt_out_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire ipfmt_pkg::ch_t ch,         // offered character
    output logic                slot_free,  // character in ch is taken this cycle
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,    // [6:0] char_code, [7] zero
    output logic                m_tlast     // last_char
);
    import ipfmt_pkg::*;

    logic       valid_reg;
    logic [6:0] code_reg;
    logic       last_reg;

    assign slot_free = !valid_reg || m_tready;

    // Track whether a transaction is pending
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (slot_free) begin
            valid_reg <= ch.valid;
        end
    end

    // Load a new character when the slot frees up
    always_ff @(posedge aclk) begin
        if (slot_free && ch.valid) begin
            code_reg <= ch.code;
            last_reg <= ch.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, code_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

/* rtl/ip_address_text_formatter_top.sv */
// Top level of the IP address text formatter: character sequencer and
// address shift register. Depends on ipfmt_pkg and ipfmt_out_stage.
//
// Usage:
//   The input channel (s_) takes one address per transaction: s_tdata holds
//   address_high in [63:0] and address_low in [127:64]; s_tuser[0] is
//   is_ipv4. The result channel (m_) returns the text form one ASCII
//   character per transaction, m_tdata[6:0], with m_tlast on the final one.
//   The block works on one address at a time; s_tready is high while no
//   address is in progress, and it rises as soon as the last character sits
//   in the output register, so the next address can enter while that
//   character still waits.
//   Work per address besides the characters themselves: a decimal split
//   per byte for IPv4 and IPv4-mapped text; for other IPv6 text a serial
//   scan for the longest zero run, a load of the first group and of the
//   group after a compressed run, and one step per skipped zero group. For
//   IPv4 the first character passes the byte split state and the digit
//   state before it reaches the output register.
//   Reset clears the sequencer and the output valid; no character is lost
//   or repeated when m_tready is held low, the sequencer simply waits.
`default_nettype none

module ip_address_text_formatter_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // [63:0] address_high, [127:64] address_low
    input  wire logic [0:0]   s_tuser,   // [0] is_ipv4
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,   // [6:0] char_code, [7] zero
    output logic              m_tlast    // last_char
);
    import ipfmt_pkg::*;

    state_t       state_reg, state_next;
    logic [127:0] addr_reg, addr_next;
    logic [7:0]   zf_reg, zf_next;
    logic [3:0]   scan_reg, scan_next;
    logic [2:0]   run_start_reg, run_start_next;
    logic [3:0]   run_len_reg, run_len_next;
    logic [2:0]   zrun_pos_reg, zrun_pos_next;
    logic [3:0]   zrun_cnt_reg, zrun_cnt_next;
    logic [2:0]   g_reg, g_next;
    logic [3:0]   skip_reg, skip_next;
    logic [15:0]  grp_reg, grp_next;
    logic [2:0]   nib_reg, nib_next;
    logic [2:0]   pfx_reg, pfx_next;
    logic [1:0]   b_reg, b_next;
    logic [11:0]  dig_reg, dig_next;
    logic [1:0]   dcnt_reg, dcnt_next;

    logic [127:0] addr_in;
    logic [7:0]   zf_in;
    logic         is_mapped;
    logic         accept;
    logic         slot_free;
    ch_t          ch;
    logic         has_best;
    logic [3:0]   best_end;
    logic         zscan;
    logic [15:0]  top16;
    logic [15:0]  grp_load;
    logic [2:0]   nib_load;
    logic         need_colon;
    dec_t         dec;

    // Address as one word, group 0 in the top bits
    assign addr_in   = {s_tdata[63:0], s_tdata[127:64]};
    assign is_mapped = (s_tdata[63:0] == 64'd0) && (s_tdata[127:96] == 32'h0000_ffff);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    // Zero flags per group, group 0 in bit 7
    for (genvar k = 0; k < 8; k++) begin : g_zf
        assign zf_in[k] = (addr_in[16*k +: 16] == 16'd0);
    end

    assign has_best = (zrun_cnt_reg != 4'd0);
    assign best_end = {1'b0, zrun_pos_reg} + zrun_cnt_reg;
    assign zscan    = !scan_reg[3] && zf_reg[7];

    // Drop leading zero nibbles of the next group, keep at least one
    assign top16 = addr_reg[127:112];
    always_comb begin
        if (top16[15:12] != 4'd0) begin
            grp_load = top16;
            nib_load = 3'd4;
        end else if (top16[11:8] != 4'd0) begin
            grp_load = {top16[11:0], 4'd0};
            nib_load = 3'd3;
        end else if (top16[7:4] != 4'd0) begin
            grp_load = {top16[7:0], 8'd0};
            nib_load = 3'd2;
        end else begin
            grp_load = {top16[3:0], 12'd0};
            nib_load = 3'd1;
        end
    end

    assign need_colon = (g_reg != 3'd0) && !(has_best && ({1'b0, g_reg} == best_end));
    assign dec        = dec8(addr_reg[127:120]);

    // Sequencer: at most one character per cycle toward the output stage, held while the output slot is busy
    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        zf_next         = zf_reg;
        scan_next       = scan_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        zrun_pos_next   = zrun_pos_reg;
        zrun_cnt_next   = zrun_cnt_reg;
        g_next          = g_reg;
        skip_next       = skip_reg;
        grp_next        = grp_reg;
        nib_next        = nib_reg;
        pfx_next        = pfx_reg;
        b_next          = b_reg;
        dig_next        = dig_reg;
        dcnt_next       = dcnt_reg;
        ch.valid        = 1'b0;
        ch.code         = CH_COLON;
        ch.last         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    zf_next        = zf_in;
                    scan_next      = 4'd0;
                    run_start_next = 3'd0;
                    run_len_next   = 4'd0;
                    zrun_pos_next  = 3'd0;
                    zrun_cnt_next  = 4'd0;
                    pfx_next       = 3'd0;
                    b_next         = 2'd0;
                    if (s_tuser[0]) begin
                        addr_next  = {s_tdata[95:64], 96'd0};
                        state_next = ST_BYTE;
                    end else if (is_mapped) begin
                        addr_next  = {s_tdata[95:64], 96'd0};
                        state_next = ST_PFX;
                    end else begin
                        addr_next  = addr_in;
                        state_next = ST_SCAN;
                    end
                end
            end

            // Find the first longest run of two or more zero groups
            ST_SCAN: begin
                zf_next   = {zf_reg[6:0], 1'b0};
                scan_next = scan_reg + 4'd1;
                if (zscan) begin
                    if (run_len_reg == 4'd0) begin
                        run_start_next = scan_reg[2:0];
                    end
                    run_len_next = run_len_reg + 4'd1;
                end else begin
                    if (run_len_reg >= 4'd2 && run_len_reg > zrun_cnt_reg) begin
                        zrun_pos_next = run_start_reg;
                        zrun_cnt_next = run_len_reg;
                    end
                    run_len_next = 4'd0;
                end
                if (scan_reg[3]) begin
                    g_next     = 3'd0;
                    state_next = ST_GRP;
                end
            end

            // Start a group: open a double colon, or emit the separating colon and load the group digits
            ST_GRP: begin
                if (has_best && g_reg == zrun_pos_reg) begin
                    ch.valid = 1'b1;
                    ch.code  = CH_COLON;
                    if (slot_free) begin
                        state_next = ST_DC2;
                    end
                end else begin
                    ch.valid = need_colon;
                    ch.code  = CH_COLON;
                    if (slot_free || !need_colon) begin
                        grp_next   = grp_load;
                        nib_next   = nib_load;
                        addr_next  = {addr_reg[111:0], 16'd0};
                        state_next = ST_HEX;
                    end
                end
            end

            ST_DC2: begin
                ch.valid = 1'b1;
                ch.code  = CH_COLON;
                ch.last  = (best_end == 4'd8);
                if (slot_free) begin
                    skip_next  = zrun_cnt_reg;
                    state_next = (best_end == 4'd8) ? ST_IDLE : ST_SKIP;
                end
            end

            // Advance past the compressed zero groups
            ST_SKIP: begin
                addr_next = {addr_reg[111:0], 16'd0};
                g_next    = g_reg + 3'd1;
                skip_next = skip_reg - 4'd1;
                if (skip_reg == 4'd1) begin
                    state_next = ST_GRP;
                end
            end

            ST_HEX: begin
                ch.valid = 1'b1;
                ch.code  = hex_char(grp_reg[15:12]);
                ch.last  = (nib_reg == 3'd1) && (g_reg == 3'd7);
                if (slot_free) begin
                    grp_next = {grp_reg[11:0], 4'd0};
                    nib_next = nib_reg - 3'd1;
                    if (nib_reg == 3'd1) begin
                        g_next     = g_reg + 3'd1;
                        state_next = (g_reg == 3'd7) ? ST_IDLE : ST_GRP;
                    end
                end
            end

            ST_PFX: begin
                ch.valid = 1'b1;
                ch.code  = MAPPED_PFX[pfx_reg];
                if (slot_free) begin
                    pfx_next = pfx_reg + 3'd1;
                    if (pfx_reg == 3'(PFX_LEN - 1)) begin
                        state_next = ST_BYTE;
                    end
                end
            end

            // Split the next byte into decimal digits
            ST_BYTE: begin
                dig_next   = dec.digits;
                dcnt_next  = dec.count;
                addr_next  = {addr_reg[119:0], 8'd0};
                state_next = ST_DEC;
            end

            ST_DEC: begin
                ch.valid = 1'b1;
                ch.code  = CH_ZERO + {3'd0, dig_reg[11:8]};
                ch.last  = (dcnt_reg == 2'd1) && (b_reg == 2'd3);
                if (slot_free) begin
                    dig_next  = {dig_reg[7:0], 4'd0};
                    dcnt_next = dcnt_reg - 2'd1;
                    if (dcnt_reg == 2'd1) begin
                        state_next = (b_reg == 2'd3) ? ST_IDLE : ST_DOT;
                    end
                end
            end

            ST_DOT: begin
                ch.valid = 1'b1;
                ch.code  = CH_DOT;
                if (slot_free) begin
                    b_next     = b_reg + 2'd1;
                    state_next = ST_BYTE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance the data path registers
    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        zf_reg         <= zf_next;
        scan_reg       <= scan_next;
        run_start_reg  <= run_start_next;
        run_len_reg    <= run_len_next;
        zrun_pos_reg   <= zrun_pos_next;
        zrun_cnt_reg   <= zrun_cnt_next;
        g_reg          <= g_next;
        skip_reg       <= skip_next;
        grp_reg        <= grp_next;
        nib_reg        <= nib_next;
        pfx_reg        <= pfx_next;
        b_reg          <= b_next;
        dig_reg        <= dig_next;
        dcnt_reg       <= dcnt_next;
    end

    ipfmt_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ch        (ch),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
